// ----- rtl/fsf_pkg.sv -----
// Shared types, codes and digit helpers for the four-digit segment formatter.
// Used by fsf_ctrl, fsf_render and four_digit_segment_formatter; no dependencies.
package fsf_pkg;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_VALUE = 2'd0,
        CMD_REL   = 2'd1,
        CMD_TIME  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    // What the display currently holds
    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_REL   = 2'd1,
        KIND_TIME  = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BLINK_HALF = 2'd0,
        CFG_MINUS      = 2'd1,
        CFG_PLUS       = 2'd2
    } cfg_idx_t;

    // Sub-mode codes
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_SET     = 2'd1;
    localparam logic [1:0] MODE_SET_MIN = 2'd1;
    localparam logic [1:0] MODE_SET_SEC = 2'd2;

    // Register reset values
    localparam logic [15:0] BLINK_HALF_RESET = 16'd500;
    localparam logic [7:0]  MINUS_RESET      = 8'd64;
    localparam logic [7:0]  PLUS_RESET       = 8'd80;

    // Clamp limits for the time display
    localparam logic [9:0] MIN_LIMIT = 10'd99;
    localparam logic [5:0] SEC_LIMIT = 6'd59;

    // Reciprocals for exact division of a 16-bit value by 10^k
    localparam logic [16:0] RECIP_10    = 17'd52429;   // shift 19
    localparam logic [16:0] RECIP_100   = 17'd83887;   // shift 23
    localparam logic [16:0] RECIP_1000  = 17'd67109;   // shift 26
    localparam logic [16:0] RECIP_10000 = 17'd107375;  // shift 30
    localparam logic [7:0]  RECIP_SMALL = 8'd205;      // shift 11, for values below 1024

    localparam int TDATA_IN_W  = 40;
    localparam int TDATA_OUT_W = 40;

    // Held content plus the blink phase that applies to this beat
    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        logic [1:0]  sub_mode;
        logic [9:0]  minutes;
        logic [5:0]  seconds;
        logic        phase;
    } view_t;

    // One display frame
    typedef struct packed {
        logic       colon_on;
        logic [7:0] digit3;
        logic [7:0] digit2;
        logic [7:0] digit1;
        logic [7:0] digit0;
    } frame_t;

    // Four low decimal digits of a 16-bit value
    typedef struct packed {
        logic [3:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } bcd4_t;

    // Segment pattern for a decimal digit, bit0 = a .. bit6 = g
    function automatic logic [7:0] seg7(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    // Times ten as shift and add
    function automatic logic [15:0] mul10(input logic [15:0] x);
        return {x[12:0], 3'b000} + {x[14:0], 1'b0};
    endfunction

    // Low four decimal digits; quotients come from parallel reciprocal products
    function automatic bcd4_t to_bcd4(input logic [15:0] x);
        logic [32:0] p1, p2, p3, p4;
        logic [15:0] q1, q2, q3, q4;
        bcd4_t r;
        p1 = 33'(x) * 33'(RECIP_10);
        p2 = 33'(x) * 33'(RECIP_100);
        p3 = 33'(x) * 33'(RECIP_1000);
        p4 = 33'(x) * 33'(RECIP_10000);
        q1 = 16'(p1 >> 19);
        q2 = 16'(p2 >> 23);
        q3 = 16'(p3 >> 26);
        q4 = 16'(p4 >> 30);
        r.ones = 4'(x  - mul10(q1));
        r.tens = 4'(q1 - mul10(q2));
        r.hund = 4'(q2 - mul10(q3));
        r.thou = 4'(q3 - mul10(q4));
        return r;
    endfunction

    // Tens and ones of a value below 100
    function automatic logic [7:0] split2(input logic [6:0] x);
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  o;
        p = 15'(x) * 15'(RECIP_SMALL);
        t = 4'(p >> 11);
        o = x - 7'(mul10(16'(t)));
        return {t, o[3:0]};
    endfunction

endpackage

// ----- rtl/fsf_ctrl.sv -----
// Content store and blink timer of the segment formatter.
// Depends on fsf_pkg; feeds fsf_render with the view of each beat.
module fsf_ctrl
    import fsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_fire,
    input  cmd_t        item_cmd,
    input  logic [15:0] item_value,
    input  logic [1:0]  item_sub_mode,
    input  logic [9:0]  item_minutes,
    input  logic [5:0]  item_seconds,
    input  logic [15:0] blink_half,
    output logic        emit_req,
    output view_t       view
);

    kind_t       kind_reg,      kind_next;
    logic [15:0] value_reg,     value_next;
    logic [1:0]  sub_mode_reg,  sub_mode_next;
    logic [9:0]  minutes_reg,   minutes_next;
    logic [5:0]  seconds_reg,   seconds_next;
    logic        blink_en_reg,  blink_en_next;
    logic        phase_reg,     phase_next;
    logic        dirty_reg,     dirty_next;
    logic [15:0] ticks_reg,     ticks_next;

    logic [15:0] ticks_inc;
    logic        toggle;
    logic        phase_tick;

    // Advance the blink timer for a tick beat
    assign ticks_inc  = ticks_reg + 16'd1;
    assign toggle     = blink_en_reg && (ticks_inc > blink_half);
    assign phase_tick = phase_reg ^ toggle;
    assign emit_req   = (item_cmd == CMD_TICK) && (dirty_reg || toggle);

    // Show the held content with the phase this tick leaves
    always_comb begin
        view.kind     = kind_reg;
        view.value    = value_reg;
        view.sub_mode = sub_mode_reg;
        view.minutes  = minutes_reg;
        view.seconds  = seconds_reg;
        view.phase    = phase_tick;
    end

    // Next state per command
    always_comb begin
        kind_next     = kind_reg;
        value_next    = value_reg;
        sub_mode_next = sub_mode_reg;
        minutes_next  = minutes_reg;
        seconds_next  = seconds_reg;
        blink_en_next = blink_en_reg;
        phase_next    = phase_reg;
        dirty_next    = dirty_reg;
        ticks_next    = ticks_reg;
        if (item_fire) begin
            unique case (item_cmd)
                CMD_VALUE, CMD_TIME: begin
                    if (item_cmd == CMD_VALUE) begin
                        kind_next  = KIND_VALUE;
                        value_next = item_value;
                    end else begin
                        kind_next    = KIND_TIME;
                        minutes_next = item_minutes;
                        seconds_next = item_seconds;
                    end
                    sub_mode_next = item_sub_mode;
                    blink_en_next = (item_sub_mode != MODE_NORMAL);
                    phase_next    = 1'b0;
                    ticks_next    = '0;
                    dirty_next    = 1'b1;
                end
                CMD_REL: begin
                    kind_next     = KIND_REL;
                    value_next    = item_value;
                    sub_mode_next = item_sub_mode;
                    blink_en_next = 1'b0;
                    dirty_next    = 1'b1;
                end
                CMD_TICK: begin
                    if (blink_en_reg) begin
                        ticks_next = toggle ? 16'd0 : ticks_inc;
                    end
                    phase_next = phase_tick;
                    dirty_next = 1'b0;
                end
                default: begin
                    dirty_next = dirty_reg;
                end
            endcase
        end
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= KIND_VALUE;
            value_reg    <= '0;
            sub_mode_reg <= '0;
            minutes_reg  <= '0;
            seconds_reg  <= '0;
            blink_en_reg <= 1'b0;
            phase_reg    <= 1'b0;
            dirty_reg    <= 1'b0;
            ticks_reg    <= '0;
        end else begin
            kind_reg     <= kind_next;
            value_reg    <= value_next;
            sub_mode_reg <= sub_mode_next;
            minutes_reg  <= minutes_next;
            seconds_reg  <= seconds_next;
            blink_en_reg <= blink_en_next;
            phase_reg    <= phase_next;
            dirty_reg    <= dirty_next;
            ticks_reg    <= ticks_next;
        end
    end

    // A value or time show restarts the blink cycle
    a_show_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && (item_cmd == CMD_VALUE || item_cmd == CMD_TIME)
        |=> !phase_reg && ticks_reg == 16'd0 && dirty_reg)
        else $error("show beat did not restart blink");

    // A tick leaves the frame clean
    a_tick_cleans: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && item_cmd == CMD_TICK |=> !dirty_reg)
        else $error("frame still dirty after tick");

    // Timer and phase stay put while blinking is off and nothing arrives
    a_timer_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !blink_en_reg && !item_fire |=> $stable(ticks_reg) && $stable(phase_reg))
        else $error("blink timer moved while idle");

    // A relative show stops blinking and keeps the timer
    a_rel_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && item_cmd == CMD_REL |=> !blink_en_reg && $stable(ticks_reg))
        else $error("relative show disturbed the blink timer");

endmodule

// ----- rtl/fsf_render.sv -----
// Frame formatting: decimal split, blanking, sign glyph and time layout.
// Depends on fsf_pkg; driven by the view from fsf_ctrl.
module fsf_render
    import fsf_pkg::*;
(
    input  view_t      view,
    input  logic [7:0] minus_glyph,
    input  logic [7:0] plus_glyph,
    output frame_t     frame
);

    logic        neg;
    logic [15:0] mag;
    logic [15:0] operand;
    bcd4_t       dec;
    logic        ge10, ge100, ge1000;
    logic [6:0]  mm;
    logic [6:0]  ss;
    logic [7:0]  mm_dig;
    logic [7:0]  ss_dig;
    logic [7:0]  sign_glyph;

    // Pick the number to split; the most negative value maps to 32768
    assign neg     = view.value[15];
    assign mag     = neg ? (~view.value + 16'd1) : view.value;
    assign operand = (view.kind == KIND_REL) ? mag : view.value;
    assign dec     = to_bcd4(operand);
    assign ge10    = operand >= 16'd10;
    assign ge100   = operand >= 16'd100;
    assign ge1000  = operand >= 16'd1000;

    // Clamp and split minutes and seconds
    assign mm     = (view.minutes > MIN_LIMIT) ? 7'(MIN_LIMIT) : 7'(view.minutes);
    assign ss     = (view.seconds > SEC_LIMIT) ? 7'(SEC_LIMIT) : 7'(view.seconds);
    assign mm_dig = split2(mm);
    assign ss_dig = split2(ss);

    assign sign_glyph = neg ? minus_glyph : plus_glyph;

    // Lay out the frame for the held kind
    always_comb begin
        frame = '0;
        case (view.kind)
            KIND_TIME: begin
                frame.colon_on = 1'b1;
                if (!(view.sub_mode == MODE_SET_MIN && view.phase)) begin
                    frame.digit0 = seg7(mm_dig[7:4]);
                    frame.digit1 = seg7(mm_dig[3:0]);
                end
                if (!(view.sub_mode == MODE_SET_SEC && view.phase)) begin
                    frame.digit2 = seg7(ss_dig[7:4]);
                    frame.digit3 = seg7(ss_dig[3:0]);
                end
            end
            KIND_REL: begin
                frame.digit1 = ge100 ? seg7(dec.hund) : 8'h00;
                frame.digit2 = ge10  ? seg7(dec.tens) : 8'h00;
                frame.digit3 = seg7(dec.ones);
                // Sign sits just left of the first digit shown
                if (!ge10) begin
                    frame.digit2 = sign_glyph;
                end else if (!ge100) begin
                    frame.digit1 = sign_glyph;
                end else begin
                    frame.digit0 = sign_glyph;
                end
            end
            default: begin
                if (!(view.sub_mode == MODE_SET && view.phase)) begin
                    frame.digit0 = ge1000 ? seg7(dec.thou) : 8'h00;
                    frame.digit1 = ge100  ? seg7(dec.hund) : 8'h00;
                    frame.digit2 = ge10   ? seg7(dec.tens) : 8'h00;
                    frame.digit3 = seg7(dec.ones);
                end
            end
        endcase
    end

endmodule

// ----- rtl/four_digit_segment_formatter.sv -----
// Top level of the four-digit segment formatter: ports, registers, skid control.
// Depends on fsf_pkg, fsf_ctrl and fsf_render.
//
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   tuser cmd, tdata value/sub_mode/minutes/seconds
//  m_        out        m_tvalid/m_tready   tdata digit0..digit3, colon_on
//  cfg_      in         cfg_we              cfg_addr index, cfg_wdata value
//
// One beat a cycle sustained while no held frame stalls an emitting tick. A beat is
// held in the input register, then the state update and the frame formatting (parallel
// reciprocal products) feed the output register that drives m_tvalid on emitting ticks.
// Reset is synchronous, active low, clears all control state and loads register defaults.
// A held frame stalls only tick beats that emit; show beats pass under a stall.
module four_digit_segment_formatter
    import fsf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // value[15:0], sub_mode[17:16],
                                              // minutes[27:18], seconds[33:28], zero pad
    input  logic [1:0]             s_tuser,   // cmd[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // digit0[7:0], digit1[15:8], digit2[23:16],
                                              // digit3[31:24], colon_on[32], zero pad
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_addr,
    input  logic [15:0]            cfg_wdata
);

    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic [15:0] in_value_reg;
    logic [1:0]  in_sub_mode_reg;
    logic [9:0]  in_minutes_reg;
    logic [5:0]  in_seconds_reg;

    logic [15:0] blink_half_reg;
    logic [7:0]  minus_reg;
    logic [7:0]  plus_reg;

    logic        out_valid_reg;
    frame_t      out_frame_reg;

    logic        emit_req;
    logic        advance;
    view_t       view;
    frame_t      frame;

    // Move the held beat on unless it emits into a full output register
    assign advance  = in_valid_reg && (!emit_req || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Capture input beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            in_cmd_reg      <= CMD_VALUE;
            in_value_reg    <= '0;
            in_sub_mode_reg <= '0;
            in_minutes_reg  <= '0;
            in_seconds_reg  <= '0;
        end else if (s_tready) begin
            in_valid_reg    <= s_tvalid;
            in_cmd_reg      <= cmd_t'(s_tuser);
            in_value_reg    <= s_tdata[15:0];
            in_sub_mode_reg <= s_tdata[17:16];
            in_minutes_reg  <= s_tdata[27:18];
            in_seconds_reg  <= s_tdata[33:28];
        end
    end

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_half_reg <= BLINK_HALF_RESET;
            minus_reg      <= MINUS_RESET;
            plus_reg       <= PLUS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_BLINK_HALF: blink_half_reg <= cfg_wdata;
                CFG_MINUS:      minus_reg      <= cfg_wdata[7:0];
                CFG_PLUS:       plus_reg       <= cfg_wdata[7:0];
                default:        blink_half_reg <= blink_half_reg;
            endcase
        end
    end

    fsf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_fire     (advance),
        .item_cmd      (in_cmd_reg),
        .item_value    (in_value_reg),
        .item_sub_mode (in_sub_mode_reg),
        .item_minutes  (in_minutes_reg),
        .item_seconds  (in_seconds_reg),
        .blink_half    (blink_half_reg),
        .emit_req      (emit_req),
        .view          (view)
    );

    fsf_render u_render (
        .view        (view),
        .minus_glyph (minus_reg),
        .plus_glyph  (plus_reg),
        .frame       (frame)
    );

    // Load a frame on an emitting tick, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_frame_reg <= '0;
        end else if (advance && emit_req) begin
            out_valid_reg <= 1'b1;
            out_frame_reg <= frame;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W - 33){1'b0}}, out_frame_reg};

endmodule
